// ===== src/fpa_pkg.sv =====
// ----------------------------------------------------------------------------
// fpa_pkg
// types and constants shared by the Q24.8 fixed-point alu pipeline
// ----------------------------------------------------------------------------
package fpa_pkg;

  localparam int unsigned NumMaxW = 48;

  typedef enum logic [3:0] {
    MODE_ADD   = 4'd0,
    MODE_SUB   = 4'd1,
    MODE_MUL   = 4'd2,
    MODE_DIV   = 4'd3,
    MODE_GT    = 4'd4,
    MODE_LT    = 4'd5,
    MODE_GE    = 4'd6,
    MODE_LE    = 4'd7,
    MODE_EQ    = 4'd8,
    MODE_NE    = 4'd9,
    MODE_MIN   = 4'd10,
    MODE_MAX   = 4'd11,
    MODE_INC   = 4'd12,
    MODE_DEC   = 4'd13,
    MODE_FROMI = 4'd14,
    MODE_TOI   = 4'd15
  } mode_e;

  typedef enum logic [1:0] {
    ERR_NONE = 2'd0,
    ERR_OVF  = 2'd1,
    ERR_DIV0 = 2'd2
  } err_e;

  typedef enum logic [1:0] {
    KIND_SIMPLE = 2'd0,
    KIND_MUL    = 2'd1,
    KIND_DIV    = 2'd2
  } kind_e;

  localparam logic [31:0] QMax = 32'h7FFF_FFFF;
  localparam logic [31:0] QMin = 32'h8000_0000;

  typedef struct packed {
    logic        [3:0]  mode;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } in_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic               compare_true;
    logic        [1:0]  error_code;
  } out_t;

  typedef struct packed {
    kind_e               kind;
    logic [31:0]         res;
    logic                cmp;
    err_e                err;
    logic                neg;
    logic [31:0]         ma;
    logic [31:0]         mb;
    logic [63:0]         prod;
    logic [31:0]         rem;
    logic [NumMaxW-1:0]  quo;
    logic [NumMaxW-1:0]  num;
  } st_t;

endpackage

// ===== src/fpa_prep.sv =====
// ----------------------------------------------------------------------------
// fpa_prep
// decode, operand magnitudes, divide-by-zero and all operations but multiply and divide
// ----------------------------------------------------------------------------
module fpa_prep #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  fpa_pkg::in_t item_i,
  output fpa_pkg::st_t st_o
);

  logic signed [31:0] a, b;
  logic [32:0] sum, dif, incv, decv;
  logic [31:0] ma, mb;
  logic [47:0] fm;
  logic gt;

  assign a = item_i.operand_a;
  assign b = item_i.operand_b;
  assign ma = a[31] ? 32'(-a) : a;
  assign mb = b[31] ? 32'(-b) : b;
  assign sum = {a[31], a} + {b[31], b};
  assign dif = {a[31], a} - {b[31], b};
  assign incv = {a[31], a} + 33'd1;
  assign decv = {a[31], a} - 33'd1;
  assign fm = 48'(ma) << FRAC_BITS;
  assign gt = a > b;

  function automatic logic [32:0] sat33(input logic [32:0] v);
    logic [32:0] r;
    r = {1'b0, v[31:0]};
    if (v[32] != v[31]) begin
      r = {1'b1, v[32] ? fpa_pkg::QMin : fpa_pkg::QMax};
    end
    return r;
  endfunction

  always_comb begin
    logic [32:0] s;
    st_o      = '0;
    st_o.kind = fpa_pkg::KIND_SIMPLE;
    st_o.err  = fpa_pkg::ERR_NONE;
    st_o.ma   = ma;
    st_o.mb   = mb;
    st_o.neg  = a[31] ^ b[31];
    s         = '0;
    unique case (fpa_pkg::mode_e'(item_i.mode))
      fpa_pkg::MODE_ADD: s = sat33(sum);
      fpa_pkg::MODE_SUB: s = sat33(dif);
      fpa_pkg::MODE_INC: s = sat33(incv);
      fpa_pkg::MODE_DEC: s = sat33(decv);
      fpa_pkg::MODE_MUL: st_o.kind = fpa_pkg::KIND_MUL;
      fpa_pkg::MODE_DIV: begin
        if (b == 32'sd0) begin
          st_o.err = fpa_pkg::ERR_DIV0;
          st_o.res = (a == 32'sd0) ? 32'd0 : (a[31] ? fpa_pkg::QMin : fpa_pkg::QMax);
        end else begin
          st_o.kind = fpa_pkg::KIND_DIV;
        end
      end
      fpa_pkg::MODE_GT: st_o.cmp = gt;
      fpa_pkg::MODE_LT: st_o.cmp = a < b;
      fpa_pkg::MODE_GE: st_o.cmp = a >= b;
      fpa_pkg::MODE_LE: st_o.cmp = !gt;
      fpa_pkg::MODE_EQ: st_o.cmp = a == b;
      fpa_pkg::MODE_NE: st_o.cmp = a != b;
      fpa_pkg::MODE_MIN: st_o.res = gt ? b : a;
      fpa_pkg::MODE_MAX: st_o.res = gt ? a : b;
      fpa_pkg::MODE_FROMI: begin
        if (!a[31] && fm > 48'h7FFF_FFFF) begin
          s = {1'b1, fpa_pkg::QMax};
        end else if (a[31] && fm > 48'h8000_0000) begin
          s = {1'b1, fpa_pkg::QMin};
        end else begin
          s = {1'b0, a[31] ? 32'(-fm[31:0]) : fm[31:0]};
        end
      end
      fpa_pkg::MODE_TOI: st_o.res = 32'(a >>> FRAC_BITS);
      default: st_o.res = '0;
    endcase
    if (s[32]) begin
      st_o.err = fpa_pkg::ERR_OVF;
    end
    if (fpa_pkg::mode_e'(item_i.mode) == fpa_pkg::MODE_ADD ||
        fpa_pkg::mode_e'(item_i.mode) == fpa_pkg::MODE_SUB ||
        fpa_pkg::mode_e'(item_i.mode) == fpa_pkg::MODE_INC ||
        fpa_pkg::mode_e'(item_i.mode) == fpa_pkg::MODE_DEC ||
        fpa_pkg::mode_e'(item_i.mode) == fpa_pkg::MODE_FROMI) begin
      st_o.res = s[31:0];
    end
  end

endmodule

// ===== src/fpa_mul.sv =====
// ----------------------------------------------------------------------------
// fpa_mul
// magnitude product and divider setup
// ----------------------------------------------------------------------------
module fpa_mul #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  fpa_pkg::st_t st_i,
  output fpa_pkg::st_t st_o
);

  localparam int unsigned NumW = 32 + FRAC_BITS;

  always_comb begin
    st_o      = st_i;
    st_o.prod = 64'(st_i.ma) * 64'(st_i.mb);
    st_o.rem  = '0;
    st_o.quo  = '0;
    st_o.num  = fpa_pkg::NumMaxW'({st_i.ma, NumW'(0)} >> 32);
  end

endmodule

// ===== src/fpa_div_step.sv =====
// ----------------------------------------------------------------------------
// fpa_div_step
// one restoring division step, one quotient bit
// ----------------------------------------------------------------------------
module fpa_div_step #(
  parameter int unsigned NUM_W = 40
) (
  input  fpa_pkg::st_t st_i,
  output fpa_pkg::st_t st_o
);

  logic [32:0] r2;
  logic        take;

  assign r2   = {st_i.rem, st_i.num[NUM_W-1]};
  assign take = r2 >= {1'b0, st_i.mb};

  always_comb begin
    st_o     = st_i;
    st_o.rem = take ? 32'(r2 - {1'b0, st_i.mb}) : r2[31:0];
    st_o.quo = {st_i.quo[fpa_pkg::NumMaxW-2:0], take};
    st_o.num = st_i.num << 1;
  end

endmodule

// ===== src/fpa_finish.sv =====
// ----------------------------------------------------------------------------
// fpa_finish
// rounding, sign and saturation for multiply and divide
// ----------------------------------------------------------------------------
module fpa_finish #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  fpa_pkg::st_t st_i,
  output fpa_pkg::out_t item_o
);

  logic [63:0] mag;

  always_comb begin
    mag = '0;
    if (st_i.kind == fpa_pkg::KIND_MUL) begin
      mag = (st_i.prod + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    end else begin
      mag = 64'(st_i.quo) + 64'({st_i.rem, 1'b0} >= {1'b0, st_i.mb});
    end
  end

  always_comb begin
    item_o.result_value = st_i.res;
    item_o.compare_true = st_i.cmp;
    item_o.error_code   = st_i.err;
    if (st_i.kind != fpa_pkg::KIND_SIMPLE) begin
      item_o.error_code = fpa_pkg::ERR_NONE;
      if (st_i.neg) begin
        if (mag > 64'h8000_0000) begin
          item_o.result_value = fpa_pkg::QMin;
          item_o.error_code   = fpa_pkg::ERR_OVF;
        end else begin
          item_o.result_value = 32'(-mag[31:0]);
        end
      end else begin
        if (mag > 64'h7FFF_FFFF) begin
          item_o.result_value = fpa_pkg::QMax;
          item_o.error_code   = fpa_pkg::ERR_OVF;
        end else begin
          item_o.result_value = mag[31:0];
        end
      end
    end
  end

endmodule

// ===== src/fixed_point_q24_8_alu_unit.sv =====
// ----------------------------------------------------------------------------
// fixed_point_q24_8_alu_unit
// pipelined signed Q24.8 fixed-point alu
// ----------------------------------------------------------------------------
// in channel: in_valid_i / in_ready_o with in_item_i (mode, operand_a,
// operand_b); out channel: out_valid_o / out_ready_i with out_item_o
// (result_value, compare_true, error_code). one result per item, in order.
// every item runs the same pipeline: input register, decode, multiplier,
// one restoring divide step per quotient bit (32 + FRAC_BITS steps),
// then rounding and saturation into the output register.
// throughput: one item per cycle while the receiver does not stall; the divide chain sets the depth.
// reset empties the pipeline; no state survives between items.
// when the receiver stalls the whole pipeline holds and in_ready_o drops;
// nothing is lost or repeated.
// ----------------------------------------------------------------------------
module fixed_point_q24_8_alu_unit #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  fpa_pkg::in_t  in_item_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output fpa_pkg::out_t out_item_o
);

  localparam int unsigned NumW = 32 + FRAC_BITS;
  localparam int unsigned NSt  = NumW + 2;

  logic          en;
  logic          in_v_q;
  fpa_pkg::in_t  in_q;
  logic [NSt-1:0] v_q;
  fpa_pkg::st_t  pipe_q [NSt];
  fpa_pkg::st_t  pipe_d [NSt];
  logic          out_v_q;
  fpa_pkg::out_t out_q, out_d;

  assign en         = !out_v_q || out_ready_i;
  assign in_ready_o = en;
  assign out_valid_o = out_v_q;
  assign out_item_o  = out_q;

  fpa_prep #(.FRAC_BITS(FRAC_BITS)) u_prep (
    .item_i(in_q),
    .st_o  (pipe_d[0])
  );

  fpa_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .st_i(pipe_q[0]),
    .st_o(pipe_d[1])
  );

  for (genvar k = 2; k < NSt; k++) begin : g_div
    fpa_div_step #(.NUM_W(NumW)) u_step (
      .st_i(pipe_q[k-1]),
      .st_o(pipe_d[k])
    );
  end

  fpa_finish #(.FRAC_BITS(FRAC_BITS)) u_finish (
    .st_i  (pipe_q[NSt-1]),
    .item_o(out_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      v_q     <= '0;
      out_v_q <= 1'b0;
    end else if (en) begin
      in_v_q  <= in_valid_i;
      v_q     <= {v_q[NSt-2:0], in_v_q};
      out_v_q <= v_q[NSt-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      in_q  <= in_item_i;
      out_q <= out_d;
      for (int i = 0; i < NSt; i++) begin
        pipe_q[i] <= pipe_d[i];
      end
    end
  end

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// checks the Q24.8 fixed-point alu against an in-bench predictor of every
// operation; directed corner items, then random items with random idling
// on both channels
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned Frac = 8;
  localparam int unsigned WatchLimit = 20000;
  localparam longint QHi = 64'sd2147483647;
  localparam longint QLo = -64'sd2147483648;

  logic           clk_i;
  logic           rst_ni;
  logic           in_valid_i;
  logic           in_ready_o;
  fpa_pkg::in_t   in_item_i;
  logic           out_valid_o;
  logic           out_ready_i;
  fpa_pkg::out_t  out_item_o;

  fpa_pkg::out_t  alu_results_q[$];
  int    n_errors;
  int    idle_cycles;
  logic  sink_hold;
  logic  out_acc;
  int    sink_wait;

  fixed_point_q24_8_alu_unit #(.FRAC_BITS(Frac)) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  function automatic longint sat(longint v, inout fpa_pkg::err_e e);
    if (v > QHi) begin
      e = fpa_pkg::ERR_OVF;
      return QHi;
    end
    if (v < QLo) begin
      e = fpa_pkg::ERR_OVF;
      return QLo;
    end
    return v;
  endfunction

  function automatic fpa_pkg::out_t alu_predict(fpa_pkg::in_t it);
    fpa_pkg::out_t   o;
    longint  a, b, r;
    longint unsigned ma, mb, p, q, rm, num;
    logic    neg;
    fpa_pkg::err_e   e;
    a = longint'(it.operand_a);
    b = longint'(it.operand_b);
    ma = (a < 0) ? longint'(-a) : a;
    mb = (b < 0) ? longint'(-b) : b;
    neg = (a < 0) != (b < 0);
    r = 0;
    e = fpa_pkg::ERR_NONE;
    o.compare_true = 1'b0;
    case (fpa_pkg::mode_e'(it.mode))
      fpa_pkg::MODE_ADD: r = sat(a + b, e);
      fpa_pkg::MODE_SUB: r = sat(a - b, e);
      fpa_pkg::MODE_MUL: begin
        p = ma * mb;
        q = (p + (64'd1 << (Frac - 1))) >> Frac;
        r = sat(neg ? -longint'(q) : longint'(q), e);
      end
      fpa_pkg::MODE_DIV: begin
        if (b == 0) begin
          e = fpa_pkg::ERR_DIV0;
          r = (a > 0) ? QHi : ((a < 0) ? QLo : 0);
        end else begin
          num = ma << Frac;
          q = num / mb;
          rm = num % mb;
          if (2 * rm >= mb) q++;
          r = sat(neg ? -longint'(q) : longint'(q), e);
        end
      end
      fpa_pkg::MODE_GT: o.compare_true = a > b;
      fpa_pkg::MODE_LT: o.compare_true = a < b;
      fpa_pkg::MODE_GE: o.compare_true = a >= b;
      fpa_pkg::MODE_LE: o.compare_true = a <= b;
      fpa_pkg::MODE_EQ: o.compare_true = a == b;
      fpa_pkg::MODE_NE: o.compare_true = a != b;
      fpa_pkg::MODE_MIN: r = (a > b) ? b : a;
      fpa_pkg::MODE_MAX: r = (a > b) ? a : b;
      fpa_pkg::MODE_INC: r = sat(a + 1, e);
      fpa_pkg::MODE_DEC: r = sat(a - 1, e);
      fpa_pkg::MODE_FROMI: r = sat(a * (64'sd1 << Frac), e);
      default: r = a >>> Frac;
    endcase
    o.result_value = r[31:0];
    o.error_code = e;
    return o;
  endfunction

  task automatic send_item(fpa_pkg::mode_e m, logic [31:0] a, logic [31:0] b);
    int gap;
    fpa_pkg::in_t it;
    gap = $urandom_range(0, 11);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    it.mode = m;
    it.operand_a = a;
    it.operand_b = b;
    in_item_i <= it;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    alu_results_q.push_back(alu_predict(it));
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF - $urandom_range(0, 3);
      1: return 32'h8000_0000 + $urandom_range(0, 3);
      2: return $urandom_range(0, 600) - 300;
      3: return {{16{1'b0}}, 16'($urandom)} - 32'h8000;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_corners();
    logic [31:0] ext[6];
    ext = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h100, 32'hFFFF_FF00, 32'hFFFF_FFFF};
    for (int i = 0; i < 16; i++) begin
      send_item(fpa_pkg::mode_e'(i), ext[i % 6], ext[(i + 1) % 6]);
    end
    send_item(fpa_pkg::MODE_DIV, 32'h100, 32'h0);
    send_item(fpa_pkg::MODE_DIV, 32'hFFFF_FF00, 32'h0);
    send_item(fpa_pkg::MODE_DIV, 32'h0, 32'h0);
    send_item(fpa_pkg::MODE_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_item(fpa_pkg::MODE_MUL, 32'h8000_0000, 32'h8000_0000);
    send_item(fpa_pkg::MODE_DIV, 32'h8000_0000, 32'h1);
    send_item(fpa_pkg::MODE_INC, 32'h7FFF_FFFF, 32'h0);
    send_item(fpa_pkg::MODE_DEC, 32'h8000_0000, 32'h0);
    send_item(fpa_pkg::MODE_TOI, 32'hFFFF_FF01, 32'h0);
  endtask

  task automatic test_random_ops();
    for (int i = 0; i < 1750; i++) begin
      send_item(fpa_pkg::mode_e'($urandom_range(0, 15)), rand_operand(), rand_operand());
    end
  endtask

  always @(negedge clk_i) begin
    int w;
    if (sink_hold) begin
      out_ready_i <= 1'b1;
    end else if (out_acc) begin
      w = $urandom_range(0, 11);
      sink_wait <= w;
      out_ready_i <= (w == 0);
    end else if (sink_wait > 1) begin
      sink_wait <= sink_wait - 1;
    end else begin
      sink_wait <= 0;
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    fpa_pkg::out_t exp_item;
    out_acc = rst_ni && out_valid_o && out_ready_i;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (alu_results_q.size() == 0) begin
        $display("%0t unexpected result %p", $time, out_item_o);
        n_errors++;
      end else begin
        exp_item = alu_results_q.pop_front();
        if (out_item_o.result_value !== exp_item.result_value) begin
          $display("%0t result_value exp %h got %h", $time,
                   exp_item.result_value, out_item_o.result_value);
          n_errors++;
        end
        if (out_item_o.compare_true !== exp_item.compare_true) begin
          $display("%0t compare_true exp %b got %b", $time,
                   exp_item.compare_true, out_item_o.compare_true);
          n_errors++;
        end
        if (out_item_o.error_code !== exp_item.error_code) begin
          $display("%0t error_code exp %0d got %0d", $time,
                   exp_item.error_code, out_item_o.error_code);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || !rst_ni) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchLimit) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    sink_hold = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_item_i = '0;
    out_ready_i = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    test_corners();
    test_random_ops();
    in_valid_i <= 1'b0;
    sink_hold = 1'b1;
    while (alu_results_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
